### design/ocu_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the orbit camera update unit.
// Used by ocu_mul, ocu_cordic and orbit_camera_update_unit. No dependencies.

package ocu_pkg;

	// CORDIC iteration count, valid range 8..24
	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam int ATAN_DEPTH   = 24;
	localparam int ATAN_IDX_W   = $clog2(ATAN_DEPTH);

	// CORDIC datapath word: sine/cosine scaled by 2^30, angle in radians * 2^30
	localparam int CS_W = 32;
	localparam logic signed [CS_W-1:0] CORDIC_X0 = 32'sh26DD3B6A;

	// shared multiplier operand widths
	localparam int MUL_A_W = 27;
	localparam int MUL_B_W = 32;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// angle formats: 1/128 degree, full turn 46080
	localparam int TURN     = 46080;
	localparam int HALF     = 23040;
	localparam int QUARTER  = 11520;
	localparam int DIST_MAX = 16777215;
	localparam int RAD_K    = 37480660;

	// orbit delta = floor((dx*384 + 5) / 10); offset keeps the dividend positive
	localparam int ORB_N_OFS   = 41943045;
	localparam int DIV10_RECIP = 53687092;
	// orbit + offset - biased quotient, always positive, then reduced mod 46080
	localparam int ORB_T_OFS   = 5484544;
	localparam int DIV45_RECIP = 5826;

	typedef enum logic [2:0] {
		CFG_ZOOM_GAIN   = 3'd0,
		CFG_PITCH_GAIN  = 3'd1,
		CFG_MIN_DIST    = 3'd2,
		CFG_PITCH_FLOOR = 3'd3,
		CFG_PITCH_CEIL  = 3'd4,
		CFG_PITCH_BIAS  = 3'd5,
		CFG_HEIGHT_BIAS = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic start;
		logic neg;
	} cordic_req_t;

	typedef struct packed {
		logic signed [14:0] ang;
		logic               neg;
	} fold_t;

	function automatic logic signed [CS_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
		logic signed [CS_W-1:0] r;
		case (idx)
			5'd0:    r = 32'sh3243F6A8;
			5'd1:    r = 32'sh1DAC6705;
			5'd2:    r = 32'sh0FADBAFC;
			5'd3:    r = 32'sh07F56EA6;
			5'd4:    r = 32'sh03FEAB76;
			5'd5:    r = 32'sh01FFD55B;
			5'd6:    r = 32'sh00FFFAAA;
			5'd7:    r = 32'sh007FFF55;
			5'd8:    r = 32'sh003FFFEA;
			5'd9:    r = 32'sh001FFFFD;
			5'd10:   r = 32'sh000FFFFF;
			5'd11:   r = 32'sh0007FFFF;
			5'd12:   r = 32'sh0003FFFF;
			5'd13:   r = 32'sh0001FFFF;
			5'd14:   r = 32'sh0000FFFF;
			5'd15:   r = 32'sh00007FFF;
			5'd16:   r = 32'sh00003FFF;
			5'd17:   r = 32'sh00001FFF;
			5'd18:   r = 32'sh00000FFF;
			5'd19:   r = 32'sh000007FF;
			5'd20:   r = 32'sh000003FF;
			5'd21:   r = 32'sh000001FF;
			5'd22:   r = 32'sh000000FF;
			5'd23:   r = 32'sh0000007F;
			default: r = '0;
		endcase
		return r;
	endfunction

	// raw angle in [0, 92160) -> signed angle in [-11520, 11520] plus half-turn flag
	function automatic fold_t fold_angle(input logic [16:0] raw);
		logic [16:0]        a;
		logic signed [17:0] s;
		fold_t              r;
		a = (raw >= 17'(TURN)) ? raw - 17'(TURN) : raw;
		s = signed'({1'b0, a});
		r.neg = 1'b0;
		if (a > 17'(QUARTER) && a <= 17'(TURN - QUARTER)) begin
			s = s - 18'(HALF);
			r.neg = 1'b1;
		end else if (a > 17'(TURN - QUARTER)) begin
			s = s - 18'(TURN);
		end
		r.ang = s[14:0];
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sd2147483647)
			r = 32'sh7FFFFFFF;
		else if (v < -34'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

### design/orbit_camera_update_unit.sv
`timescale 1ns / 1ps
// Third-person orbit camera update: kept zoom/pitch/orbit state and camera placement.
// Depends on ocu_pkg, ocu_mul and ocu_cordic.
//
// Usage:
//   One request per frame on the input channel (in_valid / in_stall): mouse wheel,
//   dx, dy, button states, player position and heading. The block updates its zoom
//   distance, pitch and orbit angle, then places the camera and presents one result
//   on the output channel (out_valid / out_stall).
//   in_stall is high for the whole computation, so a new request is not taken until
//   the previous one has reached the output register. The computation is made of two
//   CORDIC passes (one micro-rotation per cycle) and the steps of the shared
//   multiplier.
//   A finished result sits in the output register; the next request is accepted
//   meanwhile, and if the receiver still stalls when that request finishes, the
//   block holds in its last state until the output register frees up.
//   Configuration writes (cfg_valid, cfg_ready always high) must go in while idle;
//   the block itself does not enforce this. Index 7 is ignored.
//   Reset (arst_n low) restores register defaults and the kept state: distance
//   35 units, pitch 20 degrees, orbit 0. No clearing pass.

module orbit_camera_update_unit (
	input  logic               clk,
	input  logic               arst_n,
	// config write
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	// request
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [7:0]  wheel_delta,
	input  logic signed [15:0] mouse_dx,
	input  logic signed [15:0] mouse_dy,
	input  logic               left_held,
	input  logic               right_held,
	input  logic signed [31:0] player_x,
	input  logic signed [31:0] player_y,
	input  logic signed [31:0] player_z,
	input  logic [15:0]        player_heading,
	// result
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] cam_x,
	output logic signed [31:0] cam_y,
	output logic signed [31:0] cam_z,
	output logic signed [14:0] cam_pitch,
	output logic [15:0]        cam_yaw
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_ZOOM,
		S_PITCH,
		S_ORBIT,
		S_ORB_MOD,
		S_ORB_SET,
		S_CP_START,
		S_CP_RUN,
		S_H,
		S_V,
		S_CT_START,
		S_CT_RUN,
		S_X,
		S_Z,
		S_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [15:0]        zoom_gain_q, pitch_gain_q;
	logic [23:0]        min_distance_q;
	logic signed [14:0] pitch_floor_q, pitch_ceiling_q, pitch_bias_q;
	logic signed [23:0] height_bias_q;

	// kept state
	logic [23:0]        zoom_q;
	logic signed [14:0] pitch_q;
	logic [15:0]        orbit_q;

	// latched request
	logic signed [7:0]  wheel_q;
	logic signed [15:0] dx_q, dy_q;
	logic               left_q, right_q;
	logic signed [31:0] px_q, py_q, pz_q;
	logic [15:0]        heading_q;

	// working registers
	logic [21:0]        t_q;
	logic signed [25:0] h_q, v_q;
	logic signed [31:0] res_x_q, res_y_q, res_z_q;
	logic [15:0]        res_yaw_q;

	// output register
	logic               out_valid_q;
	logic signed [31:0] cam_x_q, cam_y_q, cam_z_q;
	logic signed [14:0] cam_pitch_q;
	logic [15:0]        cam_yaw_q;

	// shared units
	logic signed [ocu_pkg::MUL_A_W-1:0] mul_a;
	logic signed [ocu_pkg::MUL_B_W-1:0] mul_b;
	logic signed [ocu_pkg::MUL_P_W-1:0] mul_p;
	ocu_pkg::cordic_req_t               cor_req;
	logic signed [ocu_pkg::CS_W-1:0]    cor_z, cor_sin, cor_cos;
	logic                               cor_done;

	// datapath around the multiplier
	logic signed [23:0] zprod;
	logic signed [25:0] d_raw;
	logic [23:0]        zoom_next;
	logic signed [31:0] dy_half;
	logic signed [32:0] p_new;
	logic signed [14:0] pitch_next;
	logic signed [26:0] dx_ext, m_val;
	logic [23:0]        t_full;
	logic [21:0]        rem;
	logic signed [15:0] p_sum;
	logic [16:0]        p_raw, th_sum;
	ocu_pkg::fold_t     pitch_fold, th_fold;
	logic signed [17:0] y0, yaw_w;
	logic [15:0]        yaw_val;

	ocu_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	ocu_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (cor_req),
		.z_init  (cor_z),
		.done    (cor_done),
		.sin_val (cor_sin),
		.cos_val (cor_cos)
	);

	always_comb begin
		// zoom: d - wheel*gain, clamp low then saturate high
		zprod = signed'(mul_p[23:0]);
		d_raw = signed'({2'b00, zoom_q}) - 26'(zprod);
		if (d_raw < signed'({2'b00, min_distance_q}))
			zoom_next = min_distance_q;
		else if (d_raw > 26'(ocu_pkg::DIST_MAX))
			zoom_next = 24'(ocu_pkg::DIST_MAX);
		else
			zoom_next = d_raw[23:0];

		// pitch: floor(dy*gain/2), floor test first
		dy_half = signed'(mul_p[32:1]);
		p_new   = 33'(pitch_q) + 33'(dy_half);
		if (p_new < 33'(pitch_floor_q))
			pitch_next = pitch_floor_q;
		else if (p_new > 33'(pitch_ceiling_q))
			pitch_next = pitch_ceiling_q;
		else
			pitch_next = p_new[14:0];

		// orbit: biased dividend for the divide by ten
		dx_ext = 27'(dx_q);
		m_val  = (dx_ext <<< 8) + (dx_ext <<< 7) + 27'(ocu_pkg::ORB_N_OFS);
		t_full = 24'(orbit_q) + 24'(ocu_pkg::ORB_T_OFS) - 24'(mul_p[51:29]);
		rem    = t_q - (22'(mul_p[24:18]) * 22'(ocu_pkg::TURN));

		// sine/cosine arguments
		p_sum      = 16'(pitch_q) + 16'(pitch_bias_q);
		p_raw      = p_sum[15] ? 17'(p_sum) + 17'(ocu_pkg::TURN) : 17'(p_sum);
		pitch_fold = ocu_pkg::fold_angle(p_raw);
		th_sum     = 17'(heading_q) + 17'(orbit_q);
		th_fold    = ocu_pkg::fold_angle(th_sum);

		// yaw = (half turn - theta) mod full turn
		y0 = 18'(ocu_pkg::HALF) - signed'({1'b0, th_sum});
		if (!y0[17])
			yaw_w = y0;
		else if (y0 >= -18'(ocu_pkg::TURN))
			yaw_w = y0 + 18'(ocu_pkg::TURN);
		else
			yaw_w = y0 + 18'(2 * ocu_pkg::TURN);
		yaw_val = yaw_w[15:0];

		// multiplier operands per step
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_ZOOM: begin
				mul_a = 27'(wheel_q);
				mul_b = 32'(zoom_gain_q);
			end
			S_PITCH: begin
				mul_a = 27'(dy_q);
				mul_b = 32'(pitch_gain_q);
			end
			S_ORBIT: begin
				mul_a = m_val;
				mul_b = 32'(ocu_pkg::DIV10_RECIP);
			end
			S_ORB_MOD: begin
				mul_a = 27'(t_full[21:10]);
				mul_b = 32'(ocu_pkg::DIV45_RECIP);
			end
			S_ORB_SET: begin
				mul_a = 27'(pitch_fold.ang);
				mul_b = 32'(ocu_pkg::RAD_K);
			end
			S_CP_RUN: begin
				mul_a = 27'(zoom_q);
				mul_b = cor_cos;
			end
			S_H: begin
				mul_a = 27'(zoom_q);
				mul_b = cor_sin;
			end
			S_V: begin
				mul_a = 27'(th_fold.ang);
				mul_b = 32'(ocu_pkg::RAD_K);
			end
			S_CT_RUN: begin
				mul_a = 27'(h_q);
				mul_b = cor_sin;
			end
			S_X: begin
				mul_a = 27'(h_q);
				mul_b = cor_cos;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase

		// angle * RAD_K / 256 feeds the CORDIC
		cor_z         = mul_p[39:8];
		cor_req.start = (state_q == S_CP_START) || (state_q == S_CT_START);
		cor_req.neg   = (state_q == S_CP_START) ? pitch_fold.neg : th_fold.neg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			zoom_gain_q     <= 16'd26;
			pitch_gain_q    <= 16'd26;
			min_distance_q  <= 24'd2560;
			pitch_floor_q   <= '0;
			pitch_ceiling_q <= 15'(ocu_pkg::QUARTER);
			pitch_bias_q    <= '0;
			height_bias_q   <= '0;
			zoom_q          <= 24'd8960;
			pitch_q         <= 15'sd2560;
			orbit_q         <= '0;
			wheel_q         <= '0;
			dx_q            <= '0;
			dy_q            <= '0;
			left_q          <= 1'b0;
			right_q         <= 1'b0;
			px_q            <= '0;
			py_q            <= '0;
			pz_q            <= '0;
			heading_q       <= '0;
			t_q             <= '0;
			h_q             <= '0;
			v_q             <= '0;
			res_x_q         <= '0;
			res_y_q         <= '0;
			res_z_q         <= '0;
			res_yaw_q       <= '0;
			out_valid_q     <= 1'b0;
			cam_x_q         <= '0;
			cam_y_q         <= '0;
			cam_z_q         <= '0;
			cam_pitch_q     <= '0;
			cam_yaw_q       <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					ocu_pkg::CFG_ZOOM_GAIN:   zoom_gain_q     <= cfg_data[15:0];
					ocu_pkg::CFG_PITCH_GAIN:  pitch_gain_q    <= cfg_data[15:0];
					ocu_pkg::CFG_MIN_DIST:    min_distance_q  <= cfg_data;
					ocu_pkg::CFG_PITCH_FLOOR: pitch_floor_q   <= cfg_data[14:0];
					ocu_pkg::CFG_PITCH_CEIL:  pitch_ceiling_q <= cfg_data[14:0];
					ocu_pkg::CFG_PITCH_BIAS:  pitch_bias_q    <= cfg_data[14:0];
					ocu_pkg::CFG_HEIGHT_BIAS: height_bias_q   <= cfg_data;
					default: ;
				endcase
			end

			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						wheel_q   <= wheel_delta;
						dx_q      <= mouse_dx;
						dy_q      <= mouse_dy;
						left_q    <= left_held;
						right_q   <= right_held;
						px_q      <= player_x;
						py_q      <= player_y;
						pz_q      <= player_z;
						heading_q <= (player_heading >= 16'(ocu_pkg::TURN)) ?
							player_heading - 16'(ocu_pkg::TURN) : player_heading;
						state_q   <= S_ZOOM;
					end
				end
				S_ZOOM: state_q <= S_PITCH;
				S_PITCH: begin
					zoom_q  <= zoom_next;
					state_q <= S_ORBIT;
				end
				S_ORBIT: begin
					if (right_q)
						pitch_q <= pitch_next;
					state_q <= S_ORB_MOD;
				end
				S_ORB_MOD: begin
					t_q     <= t_full[21:0];
					state_q <= S_ORB_SET;
				end
				S_ORB_SET: begin
					if (left_q)
						orbit_q <= rem[15:0];
					state_q <= S_CP_START;
				end
				S_CP_START: state_q <= S_CP_RUN;
				S_CP_RUN: begin
					if (cor_done)
						state_q <= S_H;
				end
				S_H: begin
					h_q     <= mul_p[55:30];
					state_q <= S_V;
				end
				S_V: begin
					v_q     <= mul_p[55:30];
					state_q <= S_CT_START;
				end
				S_CT_START: state_q <= S_CT_RUN;
				S_CT_RUN: begin
					if (cor_done)
						state_q <= S_X;
				end
				S_X: begin
					res_x_q <= ocu_pkg::sat32(34'(px_q) - 34'(signed'(mul_p[56:30])));
					state_q <= S_Z;
				end
				S_Z: begin
					res_z_q   <= ocu_pkg::sat32(34'(pz_q) - 34'(signed'(mul_p[56:30])));
					res_y_q   <= ocu_pkg::sat32(34'(py_q) + 34'(v_q) + 34'(height_bias_q));
					res_yaw_q <= yaw_val;
					state_q   <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						cam_x_q     <= res_x_q;
						cam_y_q     <= res_y_q;
						cam_z_q     <= res_z_q;
						cam_pitch_q <= pitch_q;
						cam_yaw_q   <= res_yaw_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign cam_x     = cam_x_q;
	assign cam_y     = cam_y_q;
	assign cam_z     = cam_z_q;
	assign cam_pitch = cam_pitch_q;
	assign cam_yaw   = cam_yaw_q;

`ifndef ASSERT_OFF
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request accepted but block not busy next cycle");
	a_orbit_range: assert property (@(posedge clk) disable iff (!arst_n)
		orbit_q < 16'(ocu_pkg::TURN))
		else $error("orbit angle out of range");
	a_cordic_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> (state_q == S_CP_RUN || state_q == S_CT_RUN))
		else $error("cordic finished outside a wait state");
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && (!out_valid_q || !out_stall)) |=> (out_valid_q && !in_stall))
		else $error("result not loaded into output register");
`endif

endmodule

### design/ocu_mul.sv
`timescale 1ns / 1ps
// Shared signed multiplier with registered product.
// Depends on ocu_pkg for operand widths.

module ocu_mul (
	input  logic                                clk,
	input  logic signed [ocu_pkg::MUL_A_W-1:0] a,
	input  logic signed [ocu_pkg::MUL_B_W-1:0] b,
	output logic signed [ocu_pkg::MUL_P_W-1:0] p
);

	logic signed [ocu_pkg::MUL_P_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

### design/ocu_cordic.sv
`timescale 1ns / 1ps
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on ocu_pkg (step count, arctangent table, request struct).

module ocu_cordic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ocu_pkg::cordic_req_t              req,
	input  logic signed [ocu_pkg::CS_W-1:0]  z_init,
	output logic                              done,
	output logic signed [ocu_pkg::CS_W-1:0]  sin_val,
	output logic signed [ocu_pkg::CS_W-1:0]  cos_val
);

	logic signed [ocu_pkg::CS_W-1:0] x_q, y_q, z_q;
	logic [ocu_pkg::STEP_W-1:0]       cnt_q;
	logic                             busy_q, done_q, neg_q;
	logic signed [ocu_pkg::CS_W-1:0] xs, ys, at, x_nx, y_nx, z_nx;

	always_comb begin
		xs = x_q >>> cnt_q;
		ys = y_q >>> cnt_q;
		at = ocu_pkg::atan_entry(ocu_pkg::ATAN_IDX_W'(cnt_q));
		if (!z_q[ocu_pkg::CS_W-1]) begin
			x_nx = x_q - ys;
			y_nx = y_q + xs;
			z_nx = z_q - at;
		end else begin
			x_nx = x_q + ys;
			y_nx = y_q - xs;
			z_nx = z_q + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ocu_pkg::STEP_W'(ocu_pkg::CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q   <= ocu_pkg::CORDIC_X0;
			y_q   <= '0;
			z_q   <= z_init;
			neg_q <= req.neg;
		end else if (busy_q) begin
			x_q <= x_nx;
			y_q <= y_nx;
			z_q <= z_nx;
		end
	end

	// half-turn fold flips both results
	assign sin_val = neg_q ? -y_q : y_q;
	assign cos_val = neg_q ? -x_q : x_q;
	assign done    = done_q;

`ifndef ASSERT_OFF
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("cordic started while busy");
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !req.start && cnt_q == ocu_pkg::STEP_W'(ocu_pkg::CORDIC_STEPS - 1))
		|=> (done_q && !busy_q))
		else $error("cordic did not finish after last step");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("cordic done while still busy");
`endif

endmodule
